// ===== sv/ahwp_pkg.sv =====
// ----------------------------------------------------------------------------
// ahwp_pkg
// Shared constants for the arrowhead wing point block.
// ----------------------------------------------------------------------------
package ahwp_pkg;

   localparam int LANES = 4;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEAD_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEAD_HALF_WIDTH = 2'd1;

   localparam int HEAD_LENGTH_RESET     = 20;
   localparam int HEAD_HALF_WIDTH_RESET = 8;

   // lanes: one per wing coordinate
   localparam int LANE_LEFT_X  = 0;
   localparam int LANE_LEFT_Y  = 1;
   localparam int LANE_RIGHT_X = 2;
   localparam int LANE_RIGHT_Y = 3;

endpackage

// ===== sv/ahwp_if.sv =====
// ----------------------------------------------------------------------------
// ahwp_req_if / ahwp_rsp_if
// Valid/ready channels carrying arrow points and wing points.
// ----------------------------------------------------------------------------
interface ahwp_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] tail_x;
   logic signed [COORD_BITS-1:0] tail_y;
   logic signed [COORD_BITS-1:0] tip_x;
   logic signed [COORD_BITS-1:0] tip_y;
   modport source (output valid, tail_x, tail_y, tip_x, tip_y, input ready);
   modport sink   (input valid, tail_x, tail_y, tip_x, tip_y, output ready);
endinterface

interface ahwp_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] left_x;
   logic signed [COORD_BITS-1:0] left_y;
   logic signed [COORD_BITS-1:0] right_x;
   logic signed [COORD_BITS-1:0] right_y;
   modport source (output valid, left_x, left_y, right_x, right_y, input ready);
   modport sink   (input valid, left_x, left_y, right_x, right_y, output ready);
endinterface

// ===== sv/arrow_head_wing_points_core.sv =====
// ----------------------------------------------------------------------------
// arrow_head_wing_points_core
// Arrowhead wing end points from an arrow's tail and tip.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries tail and tip; rsp_chan returns left and right wing points.
//  csr_we/csr_index/csr_wdata write head length (index 0) and half-width
//  (index 1); other indexes are ignored. Write only while the block is idle.
//  The pipeline has four front stages (shaft vector, products, numerators,
//  squares), one cell per quotient bit (HEAD_BITS+2 cells) and one output
//  register with rounding-free saturation.
//  Throughput is one item per cycle while rsp_chan is not stalled; every stage holds one item.
//  The pipeline moves as a whole: it advances whenever the output register
//  is empty or being taken, so a stalled receiver freezes every stage and
//  req_chan.ready drops in the same cycle. Nothing is lost or repeated.
//  Reset (synchronous) clears all valid flags and restores head length 20
//  and half-width 8; payload registers are left as they are.
//  A zero-length arrow points along +x.
// ----------------------------------------------------------------------------
module arrow_head_wing_points_core #(
   parameter int COORD_BITS = 16,
   parameter int HEAD_BITS  = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ahwp_req_if.sink                               req_chan,
   ahwp_rsp_if.source                             rsp_chan,
   input  logic                                   csr_we,
   input  logic [ahwp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [HEAD_BITS-1:0]                   csr_wdata
);
   import ahwp_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int HB     = HEAD_BITS;
   localparam int QB     = HB + 2;          // quotient bits per lane
   localparam int SW     = 2*CB + 2;        // squared length
   localparam int XW     = 2*QB + SW + 1;   // remainder / trial width
   localparam int SIDE_W = 2*CB + 5;        // tip, lane signs, zero flag
   localparam int OW     = CB + QB + 2;     // output difference width

   logic [HB-1:0] head_len_ff, head_wid_ff;
   logic          adv;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         head_len_ff <= HB'(HEAD_LENGTH_RESET);
         head_wid_ff <= HB'(HEAD_HALF_WIDTH_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_HEAD_LENGTH:     head_len_ff <= csr_wdata;
            REG_HEAD_HALF_WIDTH: head_wid_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                 rsp_valid_ff;
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // front end
   logic               f_valid, f_zero;
   logic [SW-1:0]      f_s;
   logic [3:0][XW-1:0] f_r;
   logic [3:0]         f_neg;
   logic [CB-1:0]      f_tip_x, f_tip_y;

   ahwp_front #(.CB(CB), .HB(HB), .SW(SW), .XW(XW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .tail_x    (req_chan.tail_x),
      .tail_y    (req_chan.tail_y),
      .tip_x     (req_chan.tip_x),
      .tip_y     (req_chan.tip_y),
      .head_len  (head_len_ff),
      .head_wid  (head_wid_ff),
      .out_valid (f_valid),
      .out_s     (f_s),
      .out_r     (f_r),
      .out_neg   (f_neg),
      .out_zero  (f_zero),
      .out_tip_x (f_tip_x),
      .out_tip_y (f_tip_y)
   );

   // chain of cells, most significant quotient bit first
   logic [QB:0]                  c_valid;
   logic [QB:0][SW-1:0]          c_s;
   logic [QB:0][3:0][XW-1:0]     c_r, c_p;
   logic [QB:0][3:0][QB-1:0]     c_q;
   logic [QB:0][SIDE_W-1:0]      c_side;

   assign c_valid[0] = f_valid;
   assign c_s[0]     = f_s;
   assign c_r[0]     = f_r;
   assign c_p[0]     = '0;
   assign c_q[0]     = '0;
   assign c_side[0]  = {f_zero, f_neg, f_tip_y, f_tip_x};

   for (genvar c = 0; c < QB; c++) begin : g_cell
      ahwp_cell #(
         .SW(SW), .XW(XW), .QB(QB), .BIT(QB-1-c), .SIDE_W(SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c_valid[c]),
         .in_s      (c_s[c]),
         .in_r      (c_r[c]),
         .in_p      (c_p[c]),
         .in_q      (c_q[c]),
         .in_side   (c_side[c]),
         .out_valid (c_valid[c+1]),
         .out_s     (c_s[c+1]),
         .out_r     (c_r[c+1]),
         .out_p     (c_p[c+1]),
         .out_q     (c_q[c+1]),
         .out_side  (c_side[c+1])
      );
   end

   // output: signed offsets, tip minus offset, saturate
   logic [SIDE_W-1:0]       side;
   logic                    z;
   logic [3:0]              neg;
   logic [3:0][OW-1:0]      off, diff;
   logic [3:0][CB-1:0]      sat;
   logic [OW-1:0]           tipx_w, tipy_w, hmax, hmin;

   assign side   = c_side[QB];
   assign z      = side[SIDE_W-1];
   assign neg    = side[2*CB +: 4];
   assign tipx_w = OW'($signed(side[CB-1:0]));
   assign tipy_w = OW'($signed(side[2*CB-1:CB]));
   assign hmax   = OW'({1'b0, {(CB-1){1'b1}}});
   assign hmin   = ~hmax;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         off[k] = neg[k] ? (~OW'(c_q[QB][k]) + 1'b1) : OW'(c_q[QB][k]);
      end
      if (z) begin
         off[LANE_LEFT_X]  = OW'(head_len_ff);
         off[LANE_LEFT_Y]  = OW'(head_wid_ff);
         off[LANE_RIGHT_X] = OW'(head_len_ff);
         off[LANE_RIGHT_Y] = ~OW'(head_wid_ff) + 1'b1;
      end
      diff[LANE_LEFT_X]  = tipx_w - off[LANE_LEFT_X];
      diff[LANE_LEFT_Y]  = tipy_w - off[LANE_LEFT_Y];
      diff[LANE_RIGHT_X] = tipx_w - off[LANE_RIGHT_X];
      diff[LANE_RIGHT_Y] = tipy_w - off[LANE_RIGHT_Y];
      for (int k = 0; k < LANES; k++) begin
         if ($signed(diff[k]) > $signed(hmax)) begin
            sat[k] = hmax[CB-1:0];
         end else if ($signed(diff[k]) < $signed(hmin)) begin
            sat[k] = hmin[CB-1:0];
         end else begin
            sat[k] = diff[k][CB-1:0];
         end
      end
   end

   logic [3:0][CB-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= sat;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.left_x  = out_ff[LANE_LEFT_X];
   assign rsp_chan.left_y  = out_ff[LANE_LEFT_Y];
   assign rsp_chan.right_x = out_ff[LANE_RIGHT_X];
   assign rsp_chan.right_y = out_ff[LANE_RIGHT_Y];

endmodule

// ===== sv/ahwp_front.sv =====
// ----------------------------------------------------------------------------
// ahwp_front
// Four-stage front end: shaft vector, products, numerators and squares.
// ----------------------------------------------------------------------------
module ahwp_front #(
   parameter int CB = 16,
   parameter int HB = 10,
   parameter int SW = 2*CB+2,
   parameter int XW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [CB-1:0]        tail_x,
   input  logic [CB-1:0]        tail_y,
   input  logic [CB-1:0]        tip_x,
   input  logic [CB-1:0]        tip_y,
   input  logic [HB-1:0]        head_len,
   input  logic [HB-1:0]        head_wid,
   output logic                 out_valid,
   output logic [SW-1:0]        out_s,
   output logic [3:0][XW-1:0]   out_r,
   output logic [3:0]           out_neg,
   output logic                 out_zero,
   output logic [CB-1:0]        out_tip_x,
   output logic [CB-1:0]        out_tip_y
);
   import ahwp_pkg::*;

   localparam int PW = HB+CB+2;
   localparam int NW = HB+CB+1;

   logic [3:0] v_ff;

   // stage 1
   logic signed [CB:0] dx1_ff, dy1_ff;
   logic [CB-1:0]      tx1_ff, ty1_ff, tx2_ff, ty2_ff, tx3_ff, ty3_ff;
   logic               z1_ff, z2_ff, z3_ff;

   // stage 2
   logic signed [PW-1:0] hdx, hdy, wdx, wdy;
   logic [PW-1:0]        hdx2_ff, hdy2_ff, wdx2_ff, wdy2_ff;
   logic [CB:0]          ax, ay;
   logic [SW-1:0]        ax2, ay2, ax2_ff, ay2_ff;

   // stage 3
   logic [3:0][PW:0]     n_in;
   logic [3:0][NW-1:0]   mag3_ff;
   logic [3:0]           neg3_ff;
   logic [SW-1:0]        s3_ff;

   // stage 4
   logic [SW-1:0]        s4_ff;
   logic [3:0][XW-1:0]   r4_ff;
   logic [3:0]           neg4_ff;
   logic                 z4_ff;
   logic [CB-1:0]        tx4_ff, ty4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   assign hdx = $signed({1'b0, head_len}) * dx1_ff;
   assign hdy = $signed({1'b0, head_len}) * dy1_ff;
   assign wdx = $signed({1'b0, head_wid}) * dx1_ff;
   assign wdy = $signed({1'b0, head_wid}) * dy1_ff;
   assign ax  = dx1_ff[CB] ? (~dx1_ff + 1'b1) : dx1_ff;
   assign ay  = dy1_ff[CB] ? (~dy1_ff + 1'b1) : dy1_ff;
   assign ax2 = ax * ax;
   assign ay2 = ay * ay;

   assign n_in[LANE_LEFT_X]  = {hdx2_ff[PW-1], hdx2_ff} - {wdy2_ff[PW-1], wdy2_ff};
   assign n_in[LANE_LEFT_Y]  = {hdy2_ff[PW-1], hdy2_ff} + {wdx2_ff[PW-1], wdx2_ff};
   assign n_in[LANE_RIGHT_X] = {hdx2_ff[PW-1], hdx2_ff} + {wdy2_ff[PW-1], wdy2_ff};
   assign n_in[LANE_RIGHT_Y] = {hdy2_ff[PW-1], hdy2_ff} - {wdx2_ff[PW-1], wdx2_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= $signed({tip_x[CB-1], tip_x}) - $signed({tail_x[CB-1], tail_x});
         dy1_ff  <= $signed({tip_y[CB-1], tip_y}) - $signed({tail_y[CB-1], tail_y});
         z1_ff   <= (tip_x == tail_x) && (tip_y == tail_y);
         tx1_ff  <= tip_x;
         ty1_ff  <= tip_y;

         hdx2_ff <= hdx;
         hdy2_ff <= hdy;
         wdx2_ff <= wdx;
         wdy2_ff <= wdy;
         ax2_ff  <= ax2;
         ay2_ff  <= ay2;
         z2_ff   <= z1_ff;
         tx2_ff  <= tx1_ff;
         ty2_ff  <= ty1_ff;

         for (int k = 0; k < LANES; k++) begin
            neg3_ff[k] <= n_in[k][PW];
            mag3_ff[k] <= n_in[k][PW] ? NW'(~n_in[k] + 1'b1) : NW'(n_in[k]);
         end
         s3_ff   <= ax2_ff + ay2_ff;
         z3_ff   <= z2_ff;
         tx3_ff  <= tx2_ff;
         ty3_ff  <= ty2_ff;

         // square at full width
         for (int k = 0; k < LANES; k++) begin
            r4_ff[k] <= XW'(mag3_ff[k]) * XW'(mag3_ff[k]);
         end
         neg4_ff <= neg3_ff;
         s4_ff   <= s3_ff;
         z4_ff   <= z3_ff;
         tx4_ff  <= tx3_ff;
         ty4_ff  <= ty3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_s     = s4_ff;
   assign out_r     = r4_ff;
   assign out_neg   = neg4_ff;
   assign out_zero  = z4_ff;
   assign out_tip_x = tx4_ff;
   assign out_tip_y = ty4_ff;

endmodule

// ===== sv/ahwp_cell.sv =====
// ----------------------------------------------------------------------------
// ahwp_cell
// One quotient bit of num / sqrt(s) for all four lanes.
// Keeps r = n^2 - q^2*s and p = q*s, so a trial needs only shifts and adds.
// ----------------------------------------------------------------------------
module ahwp_cell #(
   parameter int SW     = 34,
   parameter int XW     = 64,
   parameter int QB     = 12,
   parameter int BIT    = 0,
   parameter int SIDE_W = 37
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [SW-1:0]        in_s,
   input  logic [3:0][XW-1:0]   in_r,
   input  logic [3:0][XW-1:0]   in_p,
   input  logic [3:0][QB-1:0]   in_q,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [SW-1:0]        out_s,
   output logic [3:0][XW-1:0]   out_r,
   output logic [3:0][XW-1:0]   out_p,
   output logic [3:0][QB-1:0]   out_q,
   output logic [SIDE_W-1:0]    out_side
);
   import ahwp_pkg::*;

   logic [XW-1:0]         s_wide;
   logic [3:0][XW-1:0]    trial;
   logic [3:0]            take;
   logic                  valid_ff;
   logic [SW-1:0]         s_ff;
   logic [3:0][XW-1:0]    r_ff, p_ff;
   logic [3:0][QB-1:0]    q_ff;
   logic [SIDE_W-1:0]     side_ff;

   assign s_wide = XW'(in_s);

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         trial[k] = (in_p[k] << (BIT+1)) + (s_wide << (2*BIT));
         take[k]  = trial[k] <= in_r[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LANES; k++) begin
            r_ff[k] <= take[k] ? in_r[k] - trial[k] : in_r[k];
            p_ff[k] <= take[k] ? in_p[k] + (s_wide << BIT) : in_p[k];
            q_ff[k] <= in_q[k] | (QB'(take[k]) << BIT);
         end
         s_ff    <= in_s;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_r     = r_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;

endmodule

// ===== sv/ahwp_checker.sv =====
// ----------------------------------------------------------------------------
// ahwp_checker
// Port-level checks on the arrowhead wing point block.
// ----------------------------------------------------------------------------
module ahwp_checker #(
   parameter int CB = 16
) (
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [CB-1:0] left_x,
   input logic [CB-1:0] left_y,
   input logic [CB-1:0] right_x,
   input logic [CB-1:0] right_y
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item present after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_x) && $stable(left_y)
         && $stable(right_x) && $stable(right_y))
      else $error("stalled result item changed");

   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

endmodule

bind arrow_head_wing_points_core ahwp_checker #(.CB(COORD_BITS)) u_ahwp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .left_x    (rsp_chan.left_x),
   .left_y    (rsp_chan.left_y),
   .right_x   (rsp_chan.right_x),
   .right_y   (rsp_chan.right_y)
);
